// ----- design/hpt_pkg.sv -----
// Shared constants, types and helpers for the homogeneous point transform.
package hpt_pkg;

  // Fixed-point format and thresholds
  localparam int FRAC_BITS   = 16;
  localparam int W_THRESHOLD = 8;

  // Widths
  localparam int DATA_W   = 32;
  localparam int REG_W    = 64;
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 6;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int SH_W     = SUM_W - FRAC_BITS;
  localparam int NUM_W    = DATA_W + FRAC_BITS;
  localparam int LANES    = 3;

  // Command codes
  typedef enum logic {
    CMD_POINT     = 1'b0,
    CMD_DIRECTION = 1'b1
  } cmd_e;

  // Matrix registers, column-major, two rows per word
  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));
  localparam logic [REG_W-1:0] ZERO_W = REG_W'(0);

  localparam mat_t REG_RESET = {ONE_HI, ZERO_W, ONE_LO, ZERO_W,
                                ZERO_W, ONE_HI, ZERO_W, ONE_LO};

  // Row sums handed from the matrix stage to the divide stage
  typedef struct packed {
    logic                          point;
    logic                          sat;
    logic                          wsat;
    logic [DATA_W-1:0]             w;
    logic [LANES-1:0][DATA_W-1:0]  s;
  } row_t;

  // Matrix entry for column c, row r
  function automatic logic [DATA_W-1:0] mat_entry(mat_t m, logic [1:0] c, logic [1:0] r);
    logic [REG_W-1:0] word;
    word = m[{c, r[1]}];
    return r[0] ? word[REG_W-1:DATA_W] : word[DATA_W-1:0];
  endfunction

endpackage

// ----- design/hpt_if.sv -----
// Item channel interfaces: input vectors and transformed results.
interface hpt_in_if import hpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] in_x;
  logic [DATA_W-1:0] in_y;
  logic [DATA_W-1:0] in_z;

  modport source (output valid, cmd, in_x, in_y, in_z, input ready);
  modport sink   (input valid, cmd, in_x, in_y, in_z, output ready);
endinterface

interface hpt_out_if import hpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_x;
  logic [DATA_W-1:0] out_y;
  logic [DATA_W-1:0] out_z;
  logic              w_near_zero;
  logic              saturated;

  modport source (output valid, out_x, out_y, out_z, w_near_zero, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_near_zero, saturated, output ready);
endinterface

// ----- design/hpt_cfg.sv -----
// APB register file holding the 4x4 transform matrix.
module hpt_cfg import hpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output mat_t              mat_o
);

  mat_t regs_q;
  logic [2:0] idx;

  // 8-byte registers: word index from the upper address bits
  assign idx    = paddr[ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = regs_q[idx];
  assign mat_o  = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      regs_q[idx] <= pwdata;
    end
  end

endmodule

// ----- design/hpt_mat.sv -----
// Matrix stage: multiply, two-level sum, floor shift and clamp for all four rows.
module hpt_mat import hpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              cmd_i,
  input  logic [DATA_W-1:0] x_i,
  input  logic [DATA_W-1:0] y_i,
  input  logic [DATA_W-1:0] z_i,
  input  mat_t              mat_i,
  output logic              valid_o,
  output row_t              row_o
);

  logic [3:0] v_q;
  logic [2:0] pt_q;

  logic [DATA_W-1:0]        vec_q [3];
  logic signed [PROD_W-1:0] prod_q [4][3];
  logic signed [PROD_W-1:0] wt_q [4];
  logic signed [SUM_W-1:0]  a_q [4];
  logic signed [SUM_W-1:0]  b_q [4];
  row_t                     row_q;

  logic signed [SUM_W-1:0]  tot [4];
  logic signed [SH_W-1:0]   sh [4];
  logic [DATA_W-1:0]        cl [4];
  logic [3:0]               sat;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Floor shift and clamp of each row sum
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tot[r] = a_q[r] + b_q[r];
      sh[r]  = SH_W'(tot[r] >>> FRAC_BITS);
      sat[r] = !((&sh[r][SH_W-1:DATA_W-1]) || !(|sh[r][SH_W-1:DATA_W-1]));
      if (!sat[r]) begin
        cl[r] = sh[r][DATA_W-1:0];
      end else if (sh[r][SH_W-1]) begin
        cl[r] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        cl[r] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // input register
      pt_q[0]  <= (cmd_i == CMD_POINT);
      vec_q[0] <= x_i;
      vec_q[1] <= y_i;
      vec_q[2] <= z_i;
      // products; w term is the column 3 entry scaled by one or zero
      pt_q[1] <= pt_q[0];
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(vec_q[c]) * $signed(mat_entry(mat_i, 2'(c), 2'(r)));
        end
        wt_q[r] <= pt_q[0]
                   ? (PROD_W'($signed(mat_entry(mat_i, 2'd3, 2'(r)))) <<< FRAC_BITS)
                   : '0;
      end
      // pairwise sums
      pt_q[2] <= pt_q[1];
      for (int r = 0; r < 4; r++) begin
        a_q[r] <= SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]);
        b_q[r] <= SUM_W'(prod_q[r][2]) + SUM_W'(wt_q[r]);
      end
      // final sums
      row_q.point <= pt_q[2];
      row_q.sat   <= sat[0] | sat[1] | sat[2];
      row_q.wsat  <= sat[3];
      row_q.w     <= cl[3];
      for (int r = 0; r < LANES; r++) begin
        row_q.s[r] <= cl[r];
      end
    end
  end

  assign valid_o = v_q[3];
  assign row_o   = row_q;

endmodule

// ----- design/hpt_div.sv -----
// Divide stage: perspective divide of three lanes, one quotient bit per stage.
module hpt_div import hpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  row_t              row_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] out_x_o,
  output logic [DATA_W-1:0] out_y_o,
  output logic [DATA_W-1:0] out_z_o,
  output logic              near_o,
  output logic              sat_o
);

  localparam int STAGES = NUM_W + 1;

  logic [STAGES-1:0]              v_q;
  logic                           dodiv_q [STAGES];
  logic                           near_q  [STAGES];
  logic                           sat_q   [STAGES];
  logic [DATA_W-1:0]              d_q     [STAGES];
  logic [LANES-1:0]               neg_q   [STAGES];
  logic [LANES-1:0][DATA_W-1:0]   raw_q   [STAGES];
  logic [LANES-1:0][NUM_W-1:0]    num_q   [STAGES];
  logic [LANES-1:0][DATA_W-1:0]   rem_q   [STAGES];

  logic              vout_q;
  logic [DATA_W-1:0] res_q [LANES];
  logic              nout_q;
  logic              sout_q;

  // Prep: magnitudes and threshold test
  logic [DATA_W:0]   wabs;
  logic              near;
  logic [LANES-1:0][NUM_W-1:0] nmag;
  logic [DATA_W:0]   smag [LANES];

  always_comb begin
    wabs = row_i.w[DATA_W-1] ? -{1'b1, row_i.w} : {1'b0, row_i.w};
    near = row_i.point && !(wabs > (DATA_W+1)'(W_THRESHOLD));
    for (int l = 0; l < LANES; l++) begin
      smag[l] = row_i.s[l][DATA_W-1] ? -{1'b1, row_i.s[l]} : {1'b0, row_i.s[l]};
      nmag[l] = NUM_W'(smag[l]) << FRAC_BITS;
    end
  end

  // Restoring divide step per stage
  logic [LANES-1:0][NUM_W-1:0]  num_d [STAGES];
  logic [LANES-1:0][DATA_W-1:0] rem_d [STAGES];
  logic [DATA_W:0]              trial;
  logic                         ge;

  always_comb begin
    num_d[0] = '0;
    rem_d[0] = '0;
    for (int k = 1; k < STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial       = {rem_q[k-1][l], num_q[k-1][l][NUM_W-1]};
        ge          = trial >= {1'b0, d_q[k-1]};
        rem_d[k][l] = ge ? DATA_W'(trial - {1'b0, d_q[k-1]}) : trial[DATA_W-1:0];
        num_d[k][l] = {num_q[k-1][l][NUM_W-2:0], ge};
      end
    end
  end

  // Sign, clamp and select of the final quotient
  logic [DATA_W-1:0] res [LANES];
  logic [LANES-1:0]  qsat;
  logic [NUM_W-1:0]  q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q = num_q[STAGES-1][l];
      if (neg_q[STAGES-1][l]) begin
        qsat[l] = q > (NUM_W'(1) << (DATA_W-1));
        res[l]  = qsat[l] ? {1'b1, {(DATA_W-1){1'b0}}} : -q[DATA_W-1:0];
      end else begin
        qsat[l] = q > ((NUM_W'(1) << (DATA_W-1)) - NUM_W'(1));
        res[l]  = qsat[l] ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
      end
      if (!dodiv_q[STAGES-1]) begin
        res[l]  = raw_q[STAGES-1][l];
        qsat[l] = 1'b0;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q    <= {v_q[STAGES-2:0], valid_i};
      vout_q <= v_q[STAGES-1];
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dodiv_q[0] <= row_i.point && !near;
      near_q[0]  <= near;
      sat_q[0]   <= row_i.sat | (row_i.point & row_i.wsat);
      d_q[0]     <= wabs[DATA_W-1:0];
      raw_q[0]   <= row_i.s;
      num_q[0]   <= nmag;
      rem_q[0]   <= '0;
      for (int l = 0; l < LANES; l++) begin
        neg_q[0][l] <= row_i.s[l][DATA_W-1] ^ row_i.w[DATA_W-1];
      end
      for (int k = 1; k < STAGES; k++) begin
        dodiv_q[k] <= dodiv_q[k-1];
        near_q[k]  <= near_q[k-1];
        sat_q[k]   <= sat_q[k-1];
        d_q[k]     <= d_q[k-1];
        neg_q[k]   <= neg_q[k-1];
        raw_q[k]   <= raw_q[k-1];
        num_q[k]   <= num_d[k];
        rem_q[k]   <= rem_d[k];
      end
      for (int l = 0; l < LANES; l++) begin
        res_q[l] <= res[l];
      end
      nout_q <= near_q[STAGES-1];
      sout_q <= sat_q[STAGES-1] | (|qsat);
    end
  end

  assign valid_o = vout_q;
  assign out_x_o = res_q[0];
  assign out_y_o = res_q[1];
  assign out_z_o = res_q[2];
  assign near_o  = nout_q;
  assign sat_o   = sout_q;

endmodule

// ----- design/homogeneous_point_transform.sv -----
// Top level of the homogeneous point transform.
// Transforms one vector per cycle by a 4x4 Q16.16 matrix and, for points, divides
// by w. The pipeline takes a new item every cycle unless held; an item passes from
// acceptance through multiply and row sums, a prep register, the bit-serial
// divider (one quotient bit per stage) and an output register. The whole pipeline
// holds when a result waits at the output and is not taken. The user writes the
// matrix registers over APB only while the pipeline is empty; nothing enforces it.
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  hpt_in_if.sink            in_i,
  hpt_out_if.source         out_o
);

  mat_t mat;
  logic en;
  logic mat_valid;
  row_t row;

  // Advance when the output slot is free or being taken
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  hpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat_o   (mat)
  );

  hpt_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .cmd_i   (in_i.cmd),
    .x_i     (in_i.in_x),
    .y_i     (in_i.in_y),
    .z_i     (in_i.in_z),
    .mat_i   (mat),
    .valid_o (mat_valid),
    .row_o   (row)
  );

  hpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .row_i   (row),
    .valid_o (out_o.valid),
    .out_x_o (out_o.out_x),
    .out_y_o (out_o.out_y),
    .out_z_o (out_o.out_z),
    .near_o  (out_o.w_near_zero),
    .sat_o   (out_o.saturated)
  );

endmodule
